// ----- sv/prfe_pkg.sv -----
// shared constants and types for the pulse rate float16 encoder
package prfe_pkg;

   localparam int MANTISSA_BITS_DEFAULT = 12;
   localparam int EXPONENT_BIAS_DEFAULT = 15;

   localparam int DATA_W     = 32;
   localparam int PROD_W     = 40;
   localparam int RATE_SCALE = 250;
   localparam int SHIFT_W    = 5;
   localparam int EXP_W      = 4;
   localparam int CODE_W     = 16;

   localparam logic [CODE_W-1:0] CODE_ZERO      = 16'h0000;
   localparam logic [CODE_W-1:0] CODE_SATURATED = 16'hFFFF;

   typedef struct packed {
      logic valid;
      logic special;
      logic saturated;
      logic found;
   } cell_ctl_type;

endpackage

// ----- sv/prfe_front.sv -----
// front stages: rate product, zero check and saturation compare
module prfe_front import prfe_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              req_valid,
   input  logic [DATA_W-1:0] req_pulse_count_delta,
   input  logic [DATA_W-1:0] req_elapsed_ms,
   output cell_ctl_type      dn_ctl,
   output logic [DATA_W-1:0] dn_rem,
   output logic [DATA_W-1:0] dn_ms
);

   logic              a_valid_ff, a_valid_in;
   logic              a_zero_ff, a_zero_in;
   logic [PROD_W-1:0] a_num_ff, a_num_in;
   logic [DATA_W-1:0] a_ms_ff;

   cell_ctl_type      b_ctl_ff, b_ctl_in;
   logic [DATA_W-1:0] b_rem_ff, b_rem_in;
   logic [DATA_W-1:0] b_ms_ff;
   logic              sat;

   always_comb begin
      a_valid_in = req_valid;
      a_zero_in  = (req_pulse_count_delta == '0) || (req_elapsed_ms == '0);
      a_num_in   = PROD_W'(req_pulse_count_delta) * PROD_W'(RATE_SCALE);
   end

   always_comb begin
      sat                = a_num_ff >= PROD_W'(a_ms_ff);
      b_ctl_in.valid     = a_valid_ff;
      b_ctl_in.special   = a_zero_ff || sat;
      b_ctl_in.saturated = !a_zero_ff && sat;
      b_ctl_in.found     = 1'b0;
      b_rem_in           = a_num_ff[DATA_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_ctl_ff   <= '0;
      end else if (advance) begin
         a_valid_ff <= a_valid_in;
         b_ctl_ff   <= b_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_zero_ff <= a_zero_in;
         a_num_ff  <= a_num_in;
         a_ms_ff   <= req_elapsed_ms;
         b_rem_ff  <= b_rem_in;
         b_ms_ff   <= a_ms_ff;
      end
   end

   assign dn_ctl = b_ctl_ff;
   assign dn_rem = b_rem_ff;
   assign dn_ms  = b_ms_ff;

endmodule

// ----- sv/prfe_cell.sv -----
// one divider cell: one quotient bit, leading zero count and mantissa collection
module prfe_cell import prfe_pkg::*; #(
   parameter  int MANTISSA_BITS = MANTISSA_BITS_DEFAULT,
   localparam int GOT_W         = $clog2(MANTISSA_BITS + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  cell_ctl_type             up_ctl,
   input  logic [DATA_W-1:0]        up_rem,
   input  logic [DATA_W-1:0]        up_ms,
   input  logic [MANTISSA_BITS-1:0] up_mant,
   input  logic [GOT_W-1:0]         up_got,
   input  logic [SHIFT_W-1:0]       up_shift,
   output cell_ctl_type             dn_ctl,
   output logic [DATA_W-1:0]        dn_rem,
   output logic [DATA_W-1:0]        dn_ms,
   output logic [MANTISSA_BITS-1:0] dn_mant,
   output logic [GOT_W-1:0]         dn_got,
   output logic [SHIFT_W-1:0]       dn_shift
);

   cell_ctl_type             ctl_ff, ctl_in;
   logic [DATA_W-1:0]        rem_ff, rem_in;
   logic [DATA_W-1:0]        ms_ff;
   logic [MANTISSA_BITS-1:0] mant_ff, mant_in;
   logic [GOT_W-1:0]         got_ff, got_in;
   logic [SHIFT_W-1:0]       shift_ff, shift_in;

   logic [DATA_W:0] dbl;
   logic [DATA_W:0] diff;
   logic            ge;
   logic            take;

   always_comb begin
      dbl    = {up_rem, 1'b0};
      diff   = dbl - {1'b0, up_ms};
      ge     = dbl >= {1'b0, up_ms};
      rem_in = ge ? diff[DATA_W-1:0] : dbl[DATA_W-1:0];
      take   = !up_ctl.special && (up_ctl.found || ge) &&
               (up_got != GOT_W'(MANTISSA_BITS));
      mant_in  = take ? {up_mant[MANTISSA_BITS-2:0], ge} : up_mant;
      got_in   = take ? up_got + GOT_W'(1) : up_got;
      shift_in = (!up_ctl.special && !up_ctl.found && !ge) ?
                 up_shift + SHIFT_W'(1) : up_shift;
      ctl_in       = up_ctl;
      ctl_in.found = up_ctl.found || (ge && !up_ctl.special);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff   <= rem_in;
         ms_ff    <= up_ms;
         mant_ff  <= mant_in;
         got_ff   <= got_in;
         shift_ff <= shift_in;
      end
   end

   assign dn_ctl   = ctl_ff;
   assign dn_rem   = rem_ff;
   assign dn_ms    = ms_ff;
   assign dn_mant  = mant_ff;
   assign dn_got   = got_ff;
   assign dn_shift = shift_ff;

   a_got_range: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.valid |-> got_ff <= GOT_W'(MANTISSA_BITS))
      else $error("mantissa bit count overran");

   a_found_has_bits: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.valid && ctl_ff.found |-> got_ff != '0)
      else $error("leading one found but no mantissa bit collected");

endmodule

// ----- sv/prfe_out.sv -----
// code assembly, output register and skid register
module prfe_out import prfe_pkg::*; #(
   parameter int MANTISSA_BITS = MANTISSA_BITS_DEFAULT,
   parameter int EXPONENT_BIAS = EXPONENT_BIAS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cell_ctl_type             up_ctl,
   input  logic [MANTISSA_BITS-1:0] up_mant,
   input  logic [SHIFT_W-1:0]       up_shift,
   output logic                     advance,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [CODE_W-1:0]        rsp_encoded_rate
);

   localparam logic [SHIFT_W-1:0] BIAS = SHIFT_W'(EXPONENT_BIAS);

   logic [SHIFT_W-1:0]                    expo_diff;
   logic [EXP_W-1:0]                      expo;
   logic [CODE_W+EXP_W+MANTISSA_BITS-1:0] code_ext;
   logic [CODE_W-1:0]                     item_code;
   logic                                  push;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0] rsp_code_ff, rsp_code_in;
   logic              skid_valid_ff, skid_valid_in;
   logic [CODE_W-1:0] skid_code_ff, skid_code_in;

   always_comb begin
      expo_diff = BIAS - up_shift;
      expo      = (up_shift > BIAS) ? '0 : expo_diff[EXP_W-1:0];
      code_ext  = {{CODE_W{1'b0}}, expo, up_mant};
      if (up_ctl.special) begin
         item_code = up_ctl.saturated ? CODE_SATURATED : CODE_ZERO;
      end else begin
         item_code = code_ext[CODE_W-1:0];
      end
   end

   assign advance = !skid_valid_ff;
   assign push    = up_ctl.valid && advance;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_code_in   = rsp_code_ff;
      skid_valid_in = skid_valid_ff;
      skid_code_in  = skid_code_ff;
      if (rsp_valid_ff && rsp_stall) begin
         if (push) begin
            skid_valid_in = 1'b1;
            skid_code_in  = item_code;
         end
      end else if (skid_valid_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_code_in   = skid_code_ff;
         skid_valid_in = 1'b0;
      end else begin
         rsp_valid_in = push;
         rsp_code_in  = item_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_code_ff  <= rsp_code_in;
      skid_code_ff <= skid_code_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_encoded_rate = rsp_code_ff;

   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register holds a request while output is empty");

   a_leading_one: assert property (@(posedge clock) disable iff (reset)
      up_ctl.valid && !up_ctl.special |-> up_mant[MANTISSA_BITS-1])
      else $error("mantissa reached output without its leading one");

endmodule

// ----- sv/pulse_rate_float16_encoder_top.sv -----
// top level of the pulse rate float16 encoder
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  req_pulse_count_delta, req_elapsed_ms
//  rsp      out        rsp_valid/rsp_stall  rsp_encoded_rate
//
// one request per cycle unless req_stall is high; each request passes through
// two front stages, a chain of MANTISSA_BITS + 31 divider cells and the output register
// each divider cell does one restoring quotient step on a 33-bit remainder
// reset is synchronous and clears all valid bits; payload registers are not reset
// a skid register behind the output register keeps req_stall off the rsp_stall path
// the whole chain holds only while the skid register is full
module pulse_rate_float16_encoder_top import prfe_pkg::*; #(
   parameter int MANTISSA_BITS = MANTISSA_BITS_DEFAULT,
   parameter int EXPONENT_BIAS = EXPONENT_BIAS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [DATA_W-1:0] req_pulse_count_delta,
   input  logic [DATA_W-1:0] req_elapsed_ms,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CODE_W-1:0] rsp_encoded_rate
);

   localparam int NUM_CELLS = DATA_W - 1 + MANTISSA_BITS;
   localparam int GOT_W     = $clog2(MANTISSA_BITS + 1);

   logic advance;

   cell_ctl_type             ctl_chain   [0:NUM_CELLS];
   logic [DATA_W-1:0]        rem_chain   [0:NUM_CELLS];
   logic [DATA_W-1:0]        ms_chain    [0:NUM_CELLS];
   logic [MANTISSA_BITS-1:0] mant_chain  [0:NUM_CELLS];
   logic [GOT_W-1:0]         got_chain   [0:NUM_CELLS];
   logic [SHIFT_W-1:0]       shift_chain [0:NUM_CELLS];

   assign req_stall = !advance;

   prfe_front u_front (
      .clock                 (clock),
      .reset                 (reset),
      .advance               (advance),
      .req_valid             (req_valid),
      .req_pulse_count_delta (req_pulse_count_delta),
      .req_elapsed_ms        (req_elapsed_ms),
      .dn_ctl                (ctl_chain[0]),
      .dn_rem                (rem_chain[0]),
      .dn_ms                 (ms_chain[0])
   );

   assign mant_chain[0]  = '0;
   assign got_chain[0]   = '0;
   assign shift_chain[0] = '0;

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      prfe_cell #(
         .MANTISSA_BITS (MANTISSA_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .up_ctl   (ctl_chain[i]),
         .up_rem   (rem_chain[i]),
         .up_ms    (ms_chain[i]),
         .up_mant  (mant_chain[i]),
         .up_got   (got_chain[i]),
         .up_shift (shift_chain[i]),
         .dn_ctl   (ctl_chain[i+1]),
         .dn_rem   (rem_chain[i+1]),
         .dn_ms    (ms_chain[i+1]),
         .dn_mant  (mant_chain[i+1]),
         .dn_got   (got_chain[i+1]),
         .dn_shift (shift_chain[i+1])
      );
   end

   prfe_out #(
      .MANTISSA_BITS (MANTISSA_BITS),
      .EXPONENT_BIAS (EXPONENT_BIAS)
   ) u_out (
      .clock            (clock),
      .reset            (reset),
      .up_ctl           (ctl_chain[NUM_CELLS]),
      .up_mant          (mant_chain[NUM_CELLS]),
      .up_shift         (shift_chain[NUM_CELLS]),
      .advance          (advance),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_encoded_rate (rsp_encoded_rate)
   );

endmodule

// ----- tb/pulse_rate_float16_encoder_top_test.sv -----
// self-checking testbench for the pulse rate float16 encoder top level
module pulse_rate_float16_encoder_top_test;
   import prfe_pkg::*;

   localparam int MANT_BITS   = MANTISSA_BITS_DEFAULT;
   localparam int EXP_BIAS    = EXPONENT_BIAS_DEFAULT;
   localparam int LATENCY     = MANT_BITS + 34;
   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_PCT    = 29;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic [DATA_W-1:0] count;
      logic [DATA_W-1:0] ms;
      bit                typed;
      logic [CODE_W-1:0] code;
   } rate_row_type;

   typedef struct {
      logic [DATA_W-1:0] count;
      logic [DATA_W-1:0] ms;
      logic [CODE_W-1:0] code;
   } pending_rate_type;

   localparam int DIRECTED_ROWS = 20;
   localparam rate_row_type DIRECTED_TABLE [DIRECTED_ROWS] = '{
      '{32'd0,          32'd0,          1'b1, CODE_ZERO},
      '{32'd0,          32'hFFFF_FFFF,  1'b1, CODE_ZERO},
      '{32'hFFFF_FFFF,  32'd0,          1'b1, CODE_ZERO},
      '{32'd1,          32'd1,          1'b1, CODE_SATURATED},
      '{32'd2,          32'd1,          1'b1, CODE_SATURATED},
      '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, CODE_SATURATED},
      '{32'd1,          32'd250,        1'b1, CODE_SATURATED},
      '{32'd17179870,   32'hFFFF_FFFF,  1'b1, CODE_SATURATED},
      '{32'h8000_0000,  32'hFFFF_FFFF,  1'b1, CODE_SATURATED},
      '{32'd1,          32'd251,        1'b0, CODE_ZERO},
      '{32'd1,          32'd500,        1'b0, CODE_ZERO},
      '{32'd1,          32'd501,        1'b0, CODE_ZERO},
      '{32'd17179869,   32'hFFFF_FFFF,  1'b0, CODE_ZERO},
      '{32'h00FF_FFFF,  32'hFFFF_FFFF,  1'b0, CODE_ZERO},
      '{32'd1,          32'd16384000,   1'b0, CODE_ZERO},
      '{32'd1,          32'd16384001,   1'b0, CODE_ZERO},
      '{32'd1,          32'h8000_0000,  1'b0, CODE_ZERO},
      '{32'd1,          32'h7FFF_FFFF,  1'b0, CODE_ZERO},
      '{32'd1,          32'hFFFF_FFFF,  1'b0, CODE_ZERO},
      '{32'h0000_0003,  32'hAAAA_5555,  1'b0, CODE_ZERO}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [DATA_W-1:0] req_pulse_count_delta = '0;
   logic [DATA_W-1:0] req_elapsed_ms = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [CODE_W-1:0] rsp_encoded_rate;

   pending_rate_type pending_rates[$];
   int  cycle_count = 0;
   int  mismatches = 0;
   int  requests_sent = 0;
   int  results_checked = 0;
   int  zero_codes = 0;
   int  saturated_codes = 0;
   int  underflow_codes = 0;
   int  hold_left = 0;
   bit  hold_request = 1'b0;
   bit  rsp_quiet = 1'b0;

   pulse_rate_float16_encoder_top #(
      .MANTISSA_BITS(MANT_BITS),
      .EXPONENT_BIAS(EXP_BIAS)
   ) i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_pulse_count_delta (req_pulse_count_delta),
      .req_elapsed_ms        (req_elapsed_ms),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_encoded_rate      (rsp_encoded_rate)
   );

   always #2 clock = ~clock;

   function automatic logic [CODE_W-1:0] encode_rate(input logic [DATA_W-1:0] count,
                                                     input logic [DATA_W-1:0] ms);
      logic [63:0] scaled;
      logic [63:0] mant;
      logic [63:0] expo;
      int          shift;
      if (count == 0 || ms == 0) begin
         return CODE_ZERO;
      end
      scaled = 64'(count) * 64'(RATE_SCALE);
      if (scaled >= 64'(ms)) begin
         return CODE_SATURATED;
      end
      shift = 0;
      while ((scaled << 1) < 64'(ms)) begin
         scaled = scaled << 1;
         shift++;
      end
      mant = (scaled << MANT_BITS) / 64'(ms);
      expo = (shift > EXP_BIAS) ? 64'd0 : 64'(EXP_BIAS - shift);
      return CODE_W'((expo << MANT_BITS) + mant);
   endfunction

   // entered at a falling edge, returns at the falling edge after acceptance
   task automatic offer_request(input logic [DATA_W-1:0] count, input logic [DATA_W-1:0] ms,
                                input bit typed, input logic [CODE_W-1:0] code,
                                input int idle_pct);
      pending_rate_type entry;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid             <= 1'b1;
      req_pulse_count_delta <= count;
      req_elapsed_ms        <= ms;
      do @(posedge clock); while (req_stall);
      entry.count = count;
      entry.ms    = ms;
      entry.code  = typed ? code : encode_rate(count, ms);
      pending_rates.push_back(entry);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic pick_rate_request(output logic [DATA_W-1:0] count,
                                    output logic [DATA_W-1:0] ms);
      logic [63:0] scaled;
      int          kind;
      int          k;
      kind = $urandom_range(0, 9);
      count = $urandom;
      ms    = $urandom;
      case (kind)
         0: begin
            if ($urandom_range(0, 1) == 0) count = '0;
            else ms = '0;
         end
         1, 9: begin
         end
         7: begin
            // rate right around one
            count  = $urandom_range(1, 17179869);
            scaled = 64'(count) * 64'(RATE_SCALE) + 64'($urandom_range(0, 4)) - 64'd2;
            ms     = DATA_W'(scaled);
         end
         8: begin
            count = $urandom_range(1, 255);
         end
         default: begin
            // spread over every exponent, down past the bias
            if (ms == 0) ms = 1;
            k      = $urandom_range(0, 40);
            scaled = 64'(ms) >> k;
            count  = DATA_W'(scaled / RATE_SCALE) + DATA_W'($urandom_range(0, 2));
            if (count == 0) count = 1;
         end
      endcase
   endtask

   task automatic send_random(input int items, input int idle_pct);
      logic [DATA_W-1:0] count;
      logic [DATA_W-1:0] ms;
      for (int i = 0; i < items; i++) begin
         pick_rate_request(count, ms);
         offer_request(count, ms, 1'b0, CODE_ZERO, idle_pct);
      end
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (pending_rates.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (rsp_quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      pending_rate_type entry;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (rsp_encoded_rate == CODE_ZERO) zero_codes++;
         else if (rsp_encoded_rate == CODE_SATURATED) saturated_codes++;
         else if (rsp_encoded_rate[CODE_W-1 -: EXP_W] == '0) underflow_codes++;
         if (pending_rates.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual %h",
                     $time, rsp_encoded_rate);
         end else begin
            entry = pending_rates.pop_front();
            if (rsp_encoded_rate !== entry.code) begin
               mismatches++;
               $display("%0t: count %h ms %h expected %h actual %h",
                        $time, entry.count, entry.ms, entry.code, rsp_encoded_rate);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         offer_request(DIRECTED_TABLE[i].count, DIRECTED_TABLE[i].ms,
                       DIRECTED_TABLE[i].typed, DIRECTED_TABLE[i].code, 0);
      end

      send_random(500, IDLE_PCT);

      // full rate on both sides
      rsp_quiet = 1'b1;
      send_random(300, 0);
      rsp_quiet = 1'b0;

      // output held off while requests keep coming
      hold_request = 1'b1;
      send_random(200, 0);
      wait_results_drained();

      send_random(350, IDLE_PCT);
      wait_results_drained();

      rsp_quiet = 1'b1;
      repeat (2 * LATENCY) @(posedge clock);

      $display("requests %0d, results %0d: zero %0d, saturated %0d, exponent floor %0d",
               requests_sent, results_checked, zero_codes, saturated_codes,
               underflow_codes);
      $display("random idling, full-rate burst and a %0d-cycle output hold-off were run",
               HOLD_CYCLES);
      if (mismatches == 0 && pending_rates.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- pulse_rate_float16_encoder_top.f -----
sv/prfe_pkg.sv
sv/prfe_front.sv
sv/prfe_cell.sv
sv/prfe_out.sv
sv/pulse_rate_float16_encoder_top.sv
tb/pulse_rate_float16_encoder_top_test.sv
